/* sv/shabs_pkg.sv */
// Shared types, constants and functions for the SHA-256 byte stream hasher.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package shabs_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CntW    = 6;
  localparam int unsigned FillW   = 6;
  localparam int unsigned BlockW  = 512;
  localparam int unsigned LenW    = 64;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] FillLast = 6'd63;
  localparam logic [5:0] FillLen  = 6'd55;
  localparam logic [5:0] RndLast  = 6'd63;
  localparam logic [2:0] WordLast = 3'd7;

  typedef enum logic [1:0] {
    BYTE_IN,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  typedef struct packed {
    logic            push;
    byte_sel_e       bsel;
    logic            count_bits;
    logic            load;
    logic            round;
    logic            fold;
    logic            restart;
    logic [CntW-1:0] idx;
  } shabs_cmd_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
  } shabs_sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] iv(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    unique case (i)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/shabs_ctrl.sv */
// Sequencer for the hasher: byte intake, padding, length, rounds and digest output.
// Depends on shabs_pkg; drives the datapath through shabs_cmd_t.
`default_nettype none

module shabs_ctrl import shabs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       has_byte_i,
  input  wire logic       end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            out_last_o,
  input  wire shabs_sts_t sts_i,
  output shabs_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StLen  = 3'd2;
  localparam logic [2:0] StLoad = 3'd3;
  localparam logic [2:0] StRnd  = 3'd4;
  localparam logic [2:0] StAdd  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            fin_q, fin_d;
  logic            last_q, last_d;
  logic            pad_q, pad_d;
  logic            full;

  assign full = (sts_i.fill == FillLast);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    last_d      = last_q;
    pad_d       = pad_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.bsel  = BYTE_IN;
    cmd_o.idx   = cnt_q;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.push       = has_byte_i;
          cmd_o.count_bits = has_byte_i;
          if (has_byte_i && full) begin
            fin_d   = end_i;
            pad_d   = end_i;
            state_d = StLoad;
          end else if (end_i) begin
            fin_d   = 1'b1;
            pad_d   = 1'b1;
            state_d = StPad;
          end
        end
      end
      StPad: begin
        cmd_o.push = 1'b1;
        cmd_o.bsel = pad_q ? BYTE_PAD : BYTE_ZERO;
        pad_d      = 1'b0;
        if (full) begin
          state_d = StLoad;
        end else if (sts_i.fill == FillLen) begin
          cnt_d   = '0;
          state_d = StLen;
        end
      end
      StLen: begin
        cmd_o.push = 1'b1;
        cmd_o.bsel = BYTE_LEN;
        cnt_d      = cnt_q + 1'b1;
        if (full) begin
          last_d  = 1'b1;
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = StRnd;
      end
      StRnd: begin
        cmd_o.round = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == RndLast) state_d = StAdd;
      end
      StAdd: begin
        cmd_o.fold = 1'b1;
        cnt_d      = '0;
        if (last_q)     state_d = StOut;
        else if (fin_q) state_d = StPad;
        else            state_d = StIdle;
      end
      StOut: begin
        out_valid_o = 1'b1;
        out_last_o  = (cnt_q[2:0] == WordLast);
        if (out_ready_i) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q[2:0] == WordLast) begin
            cmd_o.restart = 1'b1;
            fin_d         = 1'b0;
            last_d        = 1'b0;
            state_d       = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      last_q  <= 1'b0;
      pad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      last_q  <= last_d;
      pad_q   <= pad_d;
    end
  end

endmodule

`default_nettype wire

/* sv/shabs_dp.sv */
// Hasher datapath: block shift line doubling as schedule window, round logic,
// chaining state, fill and bit counters. Depends on shabs_pkg.
`default_nettype none

module shabs_dp import shabs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire shabs_cmd_t  cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output shabs_sts_t       sts_o,
  output logic [WordW-1:0] digest_o,
  output logic [2:0]       word_index_o
);

  logic [BlockW-1:0] blk_q, blk_d;
  logic [WordW-1:0]  h_q [8];
  logic [WordW-1:0]  v_q [8];
  logic [FillW-1:0]  fill_q;
  logic [LenW-1:0]   bits_q;
  logic [7:0]        byte_mux;
  logic [WordW-1:0]  w0, w1, w9, w14, w_new;
  logic [WordW-1:0]  s0w, s1w, bs0, bs1, ch, mj, t1, t2;

  // window word j (j = 0 oldest) sits at blk_q[511-32j -: 32]
  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];

  assign s0w   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1w   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0w + w9 + s1w;

  assign bs1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1  = v_q[7] + bs1 + ch + round_k(cmd_i.idx) + w0;
  assign bs0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2  = bs0 + mj;

  always_comb begin
    case (cmd_i.bsel)
      BYTE_IN:   byte_mux = data_byte_i;
      BYTE_PAD:  byte_mux = PadByte;
      BYTE_ZERO: byte_mux = 8'h00;
      default:   byte_mux = bits_q[{~cmd_i.idx[2:0], 3'b000} +: 8];
    endcase
  end

  always_comb begin
    blk_d = blk_q;
    if (cmd_i.push)       blk_d = {blk_q[BlockW-9:0], byte_mux};
    else if (cmd_i.round) blk_d = {blk_q[BlockW-33:0], w_new};
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (cmd_i.load) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= iv(3'(i));
      fill_q <= '0;
      bits_q <= '0;
    end else begin
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= iv(3'(i));
        fill_q <= '0;
        bits_q <= '0;
      end else begin
        if (cmd_i.fold) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        if (cmd_i.push)       fill_q <= fill_q + 1'b1;
        if (cmd_i.count_bits) bits_q <= bits_q + LenW'(8);
      end
    end
  end

  assign sts_o.fill   = fill_q;
  assign digest_o     = h_q[cmd_i.idx[2:0]];
  assign word_index_o = cmd_i.idx[2:0];

endmodule

`default_nettype wire

/* sv/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte stream hasher: stream ports, controller and datapath.
// Depends on shabs_pkg, shabs_ctrl and shabs_dp.
//
//   channel | dir | tdata                          | tuser    | tlast
//   s_axis  | in  | [7:0] data_byte                | has_byte | end_of_message
//   m_axis  | out | [31:0] digest_word, [34:32] idx | -        | last_word
//
// Each beat with a byte goes into the block shift line; every full 64-byte block then
// adds a compression pass (load, 64 rounds of the single round unit, fold).
// At end of message padding and length go in at one byte a cycle (paused while a
// full padding block compresses), then eight output beats follow, one per cycle
// when m_axis_tready is high. s_axis_tready is low while a block compresses and
// from end of message until the last digest beat has left.
// Reset loads the initial hash values; no clearing pass.
`default_nettype none

module sha256_byte_stream_hasher import shabs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tuser,  // [0] has_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic             m_axis_tlast
);

  shabs_cmd_t       cmd;
  shabs_sts_t       sts;
  logic [WordW-1:0] digest;
  logic [2:0]       word_index;

  shabs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .has_byte_i  (s_axis_tuser),
    .end_i       (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  shabs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_byte_i  (s_axis_tdata),
    .sts_o        (sts),
    .digest_o     (digest),
    .word_index_o (word_index)
  );

  assign m_axis_tdata = {5'b00000, word_index, digest};

endmodule

`default_nettype wire
